>>> sv/tsu_pkg.sv
// ----------------------------------------------------------------------------
// tsu_pkg
// Shared types and constants for triangle setup with triplanar texture coords.
// ----------------------------------------------------------------------------
`default_nettype none

package tsu_pkg;

    localparam int POS_WIDTH_DEF = 32;
    localparam int TEX_W         = 32;
    localparam int BRUSH_W       = 16;
    localparam int NODE_W        = 32;
    localparam int CNT_W         = 32;
    localparam int SCALE_W       = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int DIGIT_W       = 16;

    // corner slots 0..2, normal partial products 0..5
    localparam logic [1:0] LAST_SLOT = 2'd2;
    localparam logic [2:0] LAST_PROD = 3'd5;

    localparam logic                      ENABLE_RST  = 1'b1;
    localparam logic [SCALE_W-1:0]        SCALE_RST   = 16'd1311;
    localparam logic signed [BRUSH_W-1:0] DISCARD_RST = -16'sd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE,
        CFG_SCALE,
        CFG_DISCARD
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIFF,
        S_MSTART,
        S_MWAIT,
        S_ABS,
        S_PLANE,
        S_TEX,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       store;
        logic [1:0] slot;
        logic       count;
        logic       diff;
        logic       mul_start;
        logic [2:0] prod;
        logic       acc;
        logic       absn;
        logic       plane;
        logic       tex;
        logic [1:0] vtx;
        logic       emit;
    } t_dp_cmd;

    typedef struct packed {
        logic ok;
        logic mul_done;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> sv/tsu_mul.sv
// ----------------------------------------------------------------------------
// tsu_mul
// Signed multiplier, one 16-bit digit of the second operand per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tsu_mul #(
    parameter int POS_WIDTH = tsu_pkg::POS_WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic signed [POS_WIDTH:0]  i_a,
    input  wire logic signed [POS_WIDTH:0]  i_b,
    output logic                            o_done,
    output logic signed [2*POS_WIDTH+1:0]   o_prod
);

    localparam int DW = tsu_pkg::DIGIT_W;
    localparam int ND = (POS_WIDTH + DW - 1) / DW;
    localparam int BW = DW * ND;
    localparam int CW = $clog2(ND + 1);
    localparam int NW = 2 * POS_WIDTH + 2;

    logic [POS_WIDTH:0]        a_mag, b_mag;
    logic [POS_WIDTH-1:0]      r_a, r_hi;
    logic [BW-1:0]             r_b, r_lo;
    logic                      r_neg;
    logic [CW-1:0]             r_cnt;
    logic                      r_fix, r_done;
    logic signed [NW-1:0]      r_prod;
    logic [POS_WIDTH+DW-1:0]   s;
    logic [BW+DW-1:0]          lo_cat, b_cat;
    logic [POS_WIDTH+BW-1:0]   full;
    logic [NW-1:0]             mag_ext;

    assign a_mag   = i_a[POS_WIDTH] ? -i_a : i_a;
    assign b_mag   = i_b[POS_WIDTH] ? -i_b : i_b;
    assign s       = {{DW{1'b0}}, r_hi} + (r_a * r_b[DW-1:0]);
    assign lo_cat  = {s[DW-1:0], r_lo};
    assign b_cat   = {{DW{1'b0}}, r_b};
    assign full    = {r_hi, r_lo};
    assign mag_ext = {2'b00, full[2*POS_WIDTH-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fix;
            r_fix  <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(ND);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
                r_fix <= (r_cnt == CW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= a_mag[POS_WIDTH-1:0];
            r_b   <= BW'(b_mag[POS_WIDTH-1:0]);
            r_hi  <= '0;
            r_lo  <= '0;
            r_neg <= i_a[POS_WIDTH] ^ i_b[POS_WIDTH];
        end else if (r_cnt != '0) begin
            // retire the low digit of the running sum
            r_hi <= s[POS_WIDTH+DW-1:DW];
            r_lo <= lo_cat[BW+DW-1:DW];
            r_b  <= b_cat[BW+DW-1:DW];
        end
        if (r_fix) begin
            r_prod <= r_neg ? -mag_ext : mag_ext;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

>>> sv/tsu_ctrl.sv
// ----------------------------------------------------------------------------
// tsu_ctrl
// Sequencer: corner collection, triangle check, normal, plane and emission.
// ----------------------------------------------------------------------------
`default_nettype none

module tsu_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire tsu_pkg::t_dp_sts i_sts,
    output tsu_pkg::t_dp_cmd      o_cmd
);

    tsu_pkg::t_state r_state, n_state;
    logic [1:0]      r_corner, n_corner;
    logic [2:0]      r_prod, n_prod;
    logic [1:0]      r_vtx, n_vtx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tsu_pkg::S_IDLE;
            r_corner <= '0;
            r_prod   <= '0;
            r_vtx    <= '0;
        end else begin
            r_state  <= n_state;
            r_corner <= n_corner;
            r_prod   <= n_prod;
            r_vtx    <= n_vtx;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_corner   = r_corner;
        n_prod     = r_prod;
        n_vtx      = r_vtx;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            tsu_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.store = 1'b1;
                    o_cmd.slot  = r_corner;
                    if (r_corner == tsu_pkg::LAST_SLOT) begin
                        n_corner = '0;
                        n_state  = tsu_pkg::S_CHECK;
                    end else begin
                        n_corner = r_corner + 2'd1;
                    end
                end
            end
            tsu_pkg::S_CHECK: begin
                if (i_sts.ok) begin
                    o_cmd.count = 1'b1;
                    n_state     = tsu_pkg::S_DIFF;
                end else begin
                    n_state = tsu_pkg::S_IDLE;
                end
            end
            tsu_pkg::S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_prod     = '0;
                n_state    = tsu_pkg::S_MSTART;
            end
            tsu_pkg::S_MSTART: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.prod      = r_prod;
                n_state         = tsu_pkg::S_MWAIT;
            end
            tsu_pkg::S_MWAIT: begin
                o_cmd.prod = r_prod;
                if (i_sts.mul_done) begin
                    o_cmd.acc = 1'b1;
                    if (r_prod == tsu_pkg::LAST_PROD) begin
                        n_state = tsu_pkg::S_ABS;
                    end else begin
                        n_prod  = r_prod + 3'd1;
                        n_state = tsu_pkg::S_MSTART;
                    end
                end
            end
            tsu_pkg::S_ABS: begin
                o_cmd.absn = 1'b1;
                n_state    = tsu_pkg::S_PLANE;
            end
            tsu_pkg::S_PLANE: begin
                o_cmd.plane = 1'b1;
                n_vtx       = '0;
                n_state     = tsu_pkg::S_TEX;
            end
            tsu_pkg::S_TEX: begin
                o_cmd.tex = 1'b1;
                o_cmd.vtx = r_vtx;
                n_state   = tsu_pkg::S_EMIT;
            end
            tsu_pkg::S_EMIT: begin
                o_cmd.vtx = r_vtx;
                // hold until the output register can take the vertex
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_vtx == tsu_pkg::LAST_SLOT) begin
                        n_state = tsu_pkg::S_IDLE;
                    end else begin
                        n_vtx   = r_vtx + 2'd1;
                        n_state = tsu_pkg::S_TEX;
                    end
                end
            end
            default: begin
                n_state = tsu_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/tsu_dp.sv
// ----------------------------------------------------------------------------
// tsu_dp
// Datapath: held corners, checks, exact normal, plane pick, texture scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module tsu_dp #(
    parameter int POS_WIDTH = tsu_pkg::POS_WIDTH_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire tsu_pkg::t_dp_cmd                      i_cmd,
    output tsu_pkg::t_dp_sts                           o_sts,
    input  wire logic                                  i_cfg_we,
    input  wire logic [tsu_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [tsu_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  wire logic signed [POS_WIDTH-1:0]           i_pos_x,
    input  wire logic signed [POS_WIDTH-1:0]           i_pos_y,
    input  wire logic signed [POS_WIDTH-1:0]           i_pos_z,
    input  wire logic signed [tsu_pkg::BRUSH_W-1:0]    i_brush_id,
    input  wire logic [tsu_pkg::NODE_W-1:0]            i_node_id,
    input  wire logic                                  i_present,
    input  wire logic                                  i_reverse_winding,
    input  wire logic                                  i_out_stall,
    output logic                                       o_out_valid,
    output logic signed [POS_WIDTH-1:0]                o_out_x,
    output logic signed [POS_WIDTH-1:0]                o_out_y,
    output logic signed [POS_WIDTH-1:0]                o_out_z,
    output logic signed [tsu_pkg::TEX_W-1:0]           o_tex_u,
    output logic signed [tsu_pkg::TEX_W-1:0]           o_tex_v,
    output logic signed [tsu_pkg::BRUSH_W-1:0]         o_out_brush,
    output logic [tsu_pkg::CNT_W-1:0]                  o_tri_total,
    output logic                                       o_last_vertex
);

    localparam int P  = POS_WIDTH;
    localparam int DW = P + 1;
    localparam int NW = 2 * P + 2;
    localparam int MW = DW + tsu_pkg::SCALE_W + 1;
    localparam int TW = tsu_pkg::TEX_W;
    localparam int BR = tsu_pkg::BRUSH_W;

    localparam logic signed [MW-1:0] ROUND_HALF = {{(MW-16){1'b0}}, 16'h8000};
    localparam logic signed [MW-1:0] SAT_MAX    = {{(MW-TW+1){1'b0}}, {(TW-1){1'b1}}};
    localparam logic signed [MW-1:0] SAT_MIN    = {{(MW-TW+1){1'b1}}, {(TW-1){1'b0}}};

    typedef enum logic [2:0] {
        PL_XPOS,
        PL_XNEG,
        PL_YPOS,
        PL_YNEG,
        PL_ZPOS,
        PL_ZNEG
    } t_plane;

    // configuration
    logic                          r_enable;
    logic [tsu_pkg::SCALE_W-1:0]   r_scale;
    logic signed [BR-1:0]          r_discard;

    // held corners
    logic signed [P-1:0]           r_px [3];
    logic signed [P-1:0]           r_py [3];
    logic signed [P-1:0]           r_pz [3];
    logic signed [BR-1:0]          r_brush [3];
    logic [tsu_pkg::NODE_W-1:0]    r_node [3];
    logic                          r_pres [3];
    logic                          r_rev;

    logic [tsu_pkg::CNT_W-1:0]     r_tri;

    logic signed [DW-1:0]          r_d1 [3];
    logic signed [DW-1:0]          r_d2 [3];
    logic signed [NW-1:0]          r_n [3];
    logic [NW-1:0]                 r_a [3];
    t_plane                        r_plane;

    logic signed [DW-1:0]          mul_a, mul_b;
    logic                          mul_done;
    logic signed [NW-1:0]          mul_prod;

    logic signed [MW-1:0]          r_mu, r_mv;
    logic signed [P-1:0]           r_sx, r_sy, r_sz;
    logic signed [BR-1:0]          r_sbrush;
    logic                          r_slast;

    logic                          r_out_valid;
    logic signed [P-1:0]           r_ox, r_oy, r_oz;
    logic signed [TW-1:0]          r_ou, r_ov;
    logic signed [BR-1:0]          r_obrush;
    logic [tsu_pkg::CNT_W-1:0]     r_otri;
    logic                          r_olast;

    logic                          ok;
    logic                          out_free;
    logic [1:0]                    src;
    logic signed [DW-1:0]          ex, ey, ez, u, v;
    logic signed [tsu_pkg::SCALE_W:0] sc;
    logic signed [MW-1:0]          tu, tv, qu, qv;
    logic signed [TW-1:0]          su, sv;
    logic                          g01, g02, g10, g12;
    logic                          pos0, pos1, pos2;

    // ------------------------------------------------------------------
    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= tsu_pkg::ENABLE_RST;
            r_scale   <= tsu_pkg::SCALE_RST;
            r_discard <= tsu_pkg::DISCARD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tsu_pkg::CFG_ENABLE:  r_enable  <= i_cfg_data[0];
                tsu_pkg::CFG_SCALE:   r_scale   <= i_cfg_data;
                tsu_pkg::CFG_DISCARD: r_discard <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // corner capture and triangle check
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_px[i_cmd.slot]    <= i_pos_x;
            r_py[i_cmd.slot]    <= i_pos_y;
            r_pz[i_cmd.slot]    <= i_pos_z;
            r_brush[i_cmd.slot] <= i_brush_id;
            r_node[i_cmd.slot]  <= i_node_id;
            r_pres[i_cmd.slot]  <= i_present;
            r_rev               <= i_reverse_winding;
        end
    end

    assign ok = r_pres[0] && r_pres[1] && r_pres[2]
             && (r_node[0] != r_node[1]) && (r_node[1] != r_node[2])
             && (r_node[0] != r_node[2])
             && (r_brush[0] > r_discard) && (r_brush[1] > r_discard)
             && (r_brush[2] > r_discard);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tri <= '0;
        end else if (i_cmd.count) begin
            r_tri <= r_tri + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // edge vectors d1 = p1 - p0, d2 = p2 - p0 (index 0 x, 1 y, 2 z)
    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            r_d1[0] <= {r_px[1][P-1], r_px[1]} - {r_px[0][P-1], r_px[0]};
            r_d1[1] <= {r_py[1][P-1], r_py[1]} - {r_py[0][P-1], r_py[0]};
            r_d1[2] <= {r_pz[1][P-1], r_pz[1]} - {r_pz[0][P-1], r_pz[0]};
            r_d2[0] <= {r_px[2][P-1], r_px[2]} - {r_px[0][P-1], r_px[0]};
            r_d2[1] <= {r_py[2][P-1], r_py[2]} - {r_py[0][P-1], r_py[0]};
            r_d2[2] <= {r_pz[2][P-1], r_pz[2]} - {r_pz[0][P-1], r_pz[0]};
        end
    end

    // n = cross(d2, d1): even products start a component, odd ones subtract
    always_comb begin
        unique case (i_cmd.prod)
            3'd0:    begin mul_a = r_d2[1]; mul_b = r_d1[2]; end
            3'd1:    begin mul_a = r_d2[2]; mul_b = r_d1[1]; end
            3'd2:    begin mul_a = r_d2[2]; mul_b = r_d1[0]; end
            3'd3:    begin mul_a = r_d2[0]; mul_b = r_d1[2]; end
            3'd4:    begin mul_a = r_d2[0]; mul_b = r_d1[1]; end
            3'd5:    begin mul_a = r_d2[1]; mul_b = r_d1[0]; end
            default: begin mul_a = r_d2[1]; mul_b = r_d1[2]; end
        endcase
    end

    tsu_mul #(
        .POS_WIDTH (POS_WIDTH)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            unique case (i_cmd.prod)
                3'd0:    r_n[0] <= mul_prod;
                3'd1:    r_n[0] <= r_n[0] - mul_prod;
                3'd2:    r_n[1] <= mul_prod;
                3'd3:    r_n[1] <= r_n[1] - mul_prod;
                3'd4:    r_n[2] <= mul_prod;
                3'd5:    r_n[2] <= r_n[2] - mul_prod;
                default: ;
            endcase
        end
        if (i_cmd.absn) begin
            for (int i = 0; i < 3; i++) begin
                r_a[i] <= r_n[i][NW-1] ? -r_n[i] : r_n[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // dominant axis; ties fall through to z
    assign g01  = r_a[0] > r_a[1];
    assign g02  = r_a[0] > r_a[2];
    assign g10  = r_a[1] > r_a[0];
    assign g12  = r_a[1] > r_a[2];
    assign pos0 = !r_n[0][NW-1] && (r_n[0] != '0);
    assign pos1 = !r_n[1][NW-1] && (r_n[1] != '0);
    assign pos2 = !r_n[2][NW-1] && (r_n[2] != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.plane) begin
            priority if (g01 && g02) begin
                r_plane <= pos0 ? PL_XPOS : PL_XNEG;
            end else if (g10 && g12) begin
                r_plane <= pos1 ? PL_YPOS : PL_YNEG;
            end else begin
                r_plane <= pos2 ? PL_ZPOS : PL_ZNEG;
            end
        end
    end

    // ------------------------------------------------------------------
    // projection and scale of one vertex
    assign src = r_rev ? (tsu_pkg::LAST_SLOT - i_cmd.vtx) : i_cmd.vtx;
    assign ex  = {r_px[src][P-1], r_px[src]};
    assign ey  = {r_py[src][P-1], r_py[src]};
    assign ez  = {r_pz[src][P-1], r_pz[src]};
    assign sc  = {1'b0, r_scale};

    always_comb begin
        unique case (r_plane)
            PL_XPOS: begin u = -ez; v = -ey; end
            PL_XNEG: begin u = ez;  v = -ey; end
            PL_YPOS: begin u = ex;  v = ez;  end
            PL_YNEG: begin u = ex;  v = -ez; end
            PL_ZPOS: begin u = ex;  v = -ey; end
            PL_ZNEG: begin u = -ex; v = -ey; end
            default: begin u = ex;  v = -ey; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tex) begin
            r_mu     <= u * sc;
            r_mv     <= v * sc;
            r_sx     <= r_px[src];
            r_sy     <= r_py[src];
            r_sz     <= r_pz[src];
            r_sbrush <= r_brush[src];
            r_slast  <= (i_cmd.vtx == tsu_pkg::LAST_SLOT);
        end
    end

    // round to nearest with floor, then clamp to the 32-bit range
    assign tu = r_mu + ROUND_HALF;
    assign tv = r_mv + ROUND_HALF;
    assign qu = tu >>> 16;
    assign qv = tv >>> 16;
    assign su = (qu > SAT_MAX) ? SAT_MAX[TW-1:0] :
                (qu < SAT_MIN) ? SAT_MIN[TW-1:0] : qu[TW-1:0];
    assign sv = (qv > SAT_MAX) ? SAT_MAX[TW-1:0] :
                (qv < SAT_MIN) ? SAT_MIN[TW-1:0] : qv[TW-1:0];

    // ------------------------------------------------------------------
    // output register
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_ox     <= r_sx;
            r_oy     <= r_sy;
            r_oz     <= r_sz;
            r_ou     <= r_enable ? su : '0;
            r_ov     <= r_enable ? sv : '0;
            r_obrush <= r_sbrush;
            r_otri   <= r_tri;
            r_olast  <= r_slast;
        end
    end

    assign o_sts.ok       = ok;
    assign o_sts.mul_done = mul_done;
    assign o_sts.out_free = out_free;

    assign o_out_valid   = r_out_valid;
    assign o_out_x       = r_ox;
    assign o_out_y       = r_oy;
    assign o_out_z       = r_oz;
    assign o_tex_u       = r_ou;
    assign o_tex_v       = r_ov;
    assign o_out_brush   = r_obrush;
    assign o_tri_total   = r_otri;
    assign o_last_vertex = r_olast;

endmodule

`default_nettype wire

>>> sv/triangle_setup_triplanar_uv.sv
// ----------------------------------------------------------------------------
// triangle_setup_triplanar_uv: corners are captured one by one; the third
// starts the check, then six normal products through one shared
// 16-bit-digit multiplier, plane pick and texture for each vertex.
// A dropped triangle returns to idle. Sync active-low reset clears control,
// counter, config; held corners are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_setup_triplanar_uv #(
    parameter int POS_WIDTH = tsu_pkg::POS_WIDTH_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [tsu_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [tsu_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic signed [POS_WIDTH-1:0]           i_pos_x,
    input  wire logic signed [POS_WIDTH-1:0]           i_pos_y,
    input  wire logic signed [POS_WIDTH-1:0]           i_pos_z,
    input  wire logic signed [tsu_pkg::BRUSH_W-1:0]    i_brush_id,
    input  wire logic [tsu_pkg::NODE_W-1:0]            i_node_id,
    input  wire logic                                  i_present,
    input  wire logic                                  i_reverse_winding,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic signed [POS_WIDTH-1:0]                o_out_x,
    output logic signed [POS_WIDTH-1:0]                o_out_y,
    output logic signed [POS_WIDTH-1:0]                o_out_z,
    output logic signed [tsu_pkg::TEX_W-1:0]           o_tex_u,
    output logic signed [tsu_pkg::TEX_W-1:0]           o_tex_v,
    output logic signed [tsu_pkg::BRUSH_W-1:0]         o_out_brush,
    output logic [tsu_pkg::CNT_W-1:0]                  o_tri_total,
    output logic                                       o_last_vertex
);

    tsu_pkg::t_dp_cmd cmd;
    tsu_pkg::t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    tsu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tsu_dp #(
        .POS_WIDTH (POS_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_pos_z           (i_pos_z),
        .i_brush_id        (i_brush_id),
        .i_node_id         (i_node_id),
        .i_present         (i_present),
        .i_reverse_winding (i_reverse_winding),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_out_x           (o_out_x),
        .o_out_y           (o_out_y),
        .o_out_z           (o_out_z),
        .o_tex_u           (o_tex_u),
        .o_tex_v           (o_tex_v),
        .o_out_brush       (o_out_brush),
        .o_tri_total       (o_tri_total),
        .o_last_vertex     (o_last_vertex)
    );

endmodule

`default_nettype wire
